/* rtl/ardc_pkg.sv */
package ardc_pkg;

    // Record layout
    localparam logic [7:0] MAGIC_BYTE     = 8'h42;
    localparam int         MODE_BYTES     = 3;
    localparam int         NAME_LEN_BYTES = 2;
    localparam int         CLEN_BYTES     = 6;

    // Hash unit request for one accepted beat
    typedef struct packed {
        logic       en;       // hash this byte
        logic       restart;  // start from zero (magic byte)
        logic [7:0] data;
    } t_hash_req;

    // Hash unit status toward the deframer
    typedef struct packed {
        logic       ready;    // permutation table loaded
        logic [7:0] hash;     // running hash after the last hashed byte
    } t_hash_stat;

    // Fixed Pearson permutation
    localparam logic [7:0] PERM [256] = '{
        8'd241, 8'd18,  8'd181, 8'd164, 8'd92,  8'd237, 8'd100, 8'd216,
        8'd183, 8'd107, 8'd2,   8'd12,  8'd43,  8'd246, 8'd90,  8'd143,
        8'd251, 8'd49,  8'd228, 8'd134, 8'd215, 8'd20,  8'd193, 8'd172,
        8'd140, 8'd227, 8'd148, 8'd118, 8'd57,  8'd72,  8'd119, 8'd174,
        8'd78,  8'd14,  8'd97,  8'd3,   8'd208, 8'd252, 8'd11,  8'd195,
        8'd31,  8'd28,  8'd121, 8'd206, 8'd149, 8'd23,  8'd83,  8'd154,
        8'd223, 8'd109, 8'd89,  8'd10,  8'd178, 8'd243, 8'd42,  8'd194,
        8'd221, 8'd131, 8'd212, 8'd94,  8'd205, 8'd240, 8'd161, 8'd7,
        8'd62,  8'd214, 8'd222, 8'd219, 8'd1,   8'd84,  8'd95,  8'd58,
        8'd103, 8'd60,  8'd33,  8'd111, 8'd188, 8'd218, 8'd186, 8'd166,
        8'd146, 8'd189, 8'd201, 8'd155, 8'd68,  8'd145, 8'd44,  8'd163,
        8'd69,  8'd196, 8'd115, 8'd231, 8'd61,  8'd157, 8'd165, 8'd213,
        8'd139, 8'd112, 8'd173, 8'd191, 8'd142, 8'd88,  8'd106, 8'd250,
        8'd8,   8'd127, 8'd26,  8'd126, 8'd0,   8'd96,  8'd52,  8'd182,
        8'd113, 8'd38,  8'd242, 8'd48,  8'd204, 8'd160, 8'd15,  8'd54,
        8'd158, 8'd192, 8'd81,  8'd125, 8'd245, 8'd239, 8'd101, 8'd17,
        8'd136, 8'd110, 8'd24,  8'd53,  8'd132, 8'd117, 8'd102, 8'd153,
        8'd226, 8'd4,   8'd203, 8'd199, 8'd16,  8'd249, 8'd211, 8'd167,
        8'd55,  8'd255, 8'd254, 8'd116, 8'd122, 8'd13,  8'd236, 8'd93,
        8'd144, 8'd86,  8'd59,  8'd76,  8'd150, 8'd162, 8'd207, 8'd77,
        8'd176, 8'd32,  8'd124, 8'd171, 8'd29,  8'd45,  8'd30,  8'd67,
        8'd184, 8'd51,  8'd22,  8'd105, 8'd170, 8'd253, 8'd180, 8'd187,
        8'd130, 8'd156, 8'd98,  8'd159, 8'd220, 8'd40,  8'd133, 8'd135,
        8'd114, 8'd147, 8'd75,  8'd73,  8'd210, 8'd21,  8'd129, 8'd39,
        8'd138, 8'd91,  8'd41,  8'd235, 8'd47,  8'd185, 8'd9,   8'd82,
        8'd64,  8'd87,  8'd244, 8'd50,  8'd74,  8'd233, 8'd175, 8'd247,
        8'd120, 8'd6,   8'd169, 8'd85,  8'd66,  8'd104, 8'd80,  8'd71,
        8'd230, 8'd152, 8'd225, 8'd34,  8'd248, 8'd198, 8'd63,  8'd168,
        8'd179, 8'd141, 8'd137, 8'd5,   8'd19,  8'd79,  8'd232, 8'd128,
        8'd202, 8'd46,  8'd70,  8'd37,  8'd209, 8'd217, 8'd123, 8'd27,
        8'd177, 8'd25,  8'd56,  8'd65,  8'd229, 8'd36,  8'd197, 8'd234,
        8'd108, 8'd35,  8'd151, 8'd238, 8'd200, 8'd224, 8'd99,  8'd190
    };

endpackage

/* rtl/archive_record_deframer_check.sv */
// Pipeline: an accepted beat passes two stages, the pending register and then the output register.
// Throughput: one byte per cycle while the table is loaded and the output is not stalled; the Pearson
// step is one read of the table RAM per byte, with the RAM read register feeding the next address directly.
// Reset (synchronous, active low) clears record state and the sticky halt, sets r_verify,
// then loads the 256-entry permutation RAM with s_axis_tready low.
module archive_record_deframer_check (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]    s_axis_tuser,   // [0] cmd
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [103:0]  m_axis_tdata,   // [7:0] byte_out, [31:8] mode_value,
                                          // [47:32] name_length, [95:48] body_len,
                                          // [103:96] computed_hash
    output logic [3:0]    m_axis_tuser,   // [3:0] kind
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata
);

    import ardc_pkg::*;

    localparam logic [2:0] PH_MAGIC = 3'd0;
    localparam logic [2:0] PH_MODE  = 3'd1;
    localparam logic [2:0] PH_NLEN  = 3'd2;
    localparam logic [2:0] PH_CLEN  = 3'd3;
    localparam logic [2:0] PH_NAME  = 3'd4;
    localparam logic [2:0] PH_BODY  = 3'd5;
    localparam logic [2:0] PH_HASH  = 3'd6;

    localparam logic [3:0] K_HDR    = 4'd0;
    localparam logic [3:0] K_NAME   = 4'd1;
    localparam logic [3:0] K_BODY   = 4'd2;
    localparam logic [3:0] K_OK     = 4'd3;
    localparam logic [3:0] K_BAD    = 4'd4;
    localparam logic [3:0] K_BADMAG = 4'd5;
    localparam logic [3:0] K_TRUNC  = 4'd6;
    localparam logic [3:0] K_HALT   = 4'd7;
    localparam logic [3:0] K_CLEAN  = 4'd8;

    logic [2:0]  r_phase, n_phase;
    logic [47:0] r_cnt, n_cnt;
    logic [23:0] r_mode, n_mode;
    logic [15:0] r_nlen, n_nlen;
    logic [47:0] r_clen, n_clen;
    logic        r_halt, n_halt;
    logic        r_verify;

    logic        r_p_valid;
    logic [3:0]  r_p_kind;
    logic [7:0]  r_p_byte;

    logic        r_o_valid;
    logic [3:0]  r_o_kind;
    logic [7:0]  r_o_byte;
    logic [23:0] r_o_mode;
    logic [15:0] r_o_nlen;
    logic [47:0] r_o_clen;
    logic [7:0]  r_o_hash;

    logic        accept;
    logic        p_move;
    logic [3:0]  kind;
    logic [7:0]  echo;
    logic [7:0]  b;
    logic [47:0] cnt_inc;
    t_hash_req   hreq;
    t_hash_stat  hstat;

    assign b       = s_axis_tdata;
    assign cnt_inc = r_cnt + 48'd1;

    // handshake: pending stage moves on when the output register frees up
    assign p_move        = r_p_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = hstat.ready && (!r_p_valid || p_move);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // record parser
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_mode  = r_mode;
        n_nlen  = r_nlen;
        n_clen  = r_clen;
        n_halt  = r_halt;
        kind    = K_HDR;
        echo    = 8'd0;
        hreq    = '0;
        hreq.data = b;
        if (r_halt) begin
            kind = K_HALT;
        end else if (s_axis_tuser[0]) begin
            if (r_phase == PH_MAGIC) begin
                kind = K_CLEAN;
            end else begin
                kind   = K_TRUNC;
                n_halt = 1'b1;
            end
        end else begin
            case (r_phase)
                PH_MAGIC: begin
                    if (b != MAGIC_BYTE) begin
                        kind   = K_BADMAG;
                        n_halt = 1'b1;
                    end else begin
                        n_mode       = '0;
                        n_nlen       = '0;
                        n_clen       = '0;
                        n_cnt        = '0;
                        hreq.en      = 1'b1;
                        hreq.restart = 1'b1;
                        n_phase      = PH_MODE;
                    end
                end
                PH_MODE: begin
                    hreq.en = 1'b1;
                    n_mode  = {r_mode[15:0], b};
                    n_cnt   = cnt_inc;
                    if (cnt_inc >= 48'(MODE_BYTES)) begin
                        n_cnt   = '0;
                        n_phase = PH_NLEN;
                    end
                end
                PH_NLEN: begin
                    hreq.en = 1'b1;
                    n_nlen  = {r_nlen[7:0], b};
                    n_cnt   = cnt_inc;
                    if (cnt_inc >= 48'(NAME_LEN_BYTES)) begin
                        n_cnt   = '0;
                        n_phase = PH_CLEN;
                    end
                end
                PH_CLEN: begin
                    hreq.en = 1'b1;
                    n_clen  = {r_clen[39:0], b};
                    n_cnt   = cnt_inc;
                    if (cnt_inc >= 48'(CLEN_BYTES)) begin
                        n_cnt = '0;
                        // skip empty name and content parts
                        if (r_nlen != 16'd0) begin
                            n_phase = PH_NAME;
                        end else if (n_clen != 48'd0) begin
                            n_phase = PH_BODY;
                        end else begin
                            n_phase = PH_HASH;
                        end
                    end
                end
                PH_NAME: begin
                    hreq.en = 1'b1;
                    kind    = K_NAME;
                    echo    = b;
                    n_cnt   = cnt_inc;
                    if (cnt_inc >= {32'd0, r_nlen}) begin
                        n_cnt   = '0;
                        n_phase = (r_clen != 48'd0) ? PH_BODY : PH_HASH;
                    end
                end
                PH_BODY: begin
                    hreq.en = 1'b1;
                    kind    = K_BODY;
                    echo    = b;
                    n_cnt   = cnt_inc;
                    if (cnt_inc >= r_clen) begin
                        n_cnt   = '0;
                        n_phase = PH_HASH;
                    end
                end
                default: begin
                    // hash byte: compare against hash of everything before it; always OK when r_verify is clear
                    kind    = (!r_verify || b == hstat.hash) ? K_OK : K_BAD;
                    n_cnt   = '0;
                    n_phase = PH_MAGIC;
                end
            endcase
        end
        if (!accept) begin
            hreq.en = 1'b0;
        end
    end

    ardc_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (hreq),
        .o_stat  (hstat)
    );

    // record state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_cnt   <= '0;
            r_mode  <= '0;
            r_nlen  <= '0;
            r_clen  <= '0;
            r_halt  <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_mode  <= n_mode;
            r_nlen  <= n_nlen;
            r_clen  <= n_clen;
            r_halt  <= n_halt;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_verify <= 1'b1;
        end else if (i_cfg_we) begin
            r_verify <= i_cfg_wdata;
        end
    end

    // pending stage: waits for the registered hash RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (accept) begin
            r_p_valid <= 1'b1;
        end else if (p_move) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_kind <= kind;
            r_p_byte <= echo;
        end
    end

    // output register; record state still reflects the pending beat here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (p_move) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_move) begin
            r_o_kind <= r_p_kind;
            r_o_byte <= r_p_byte;
            r_o_mode <= r_mode;
            r_o_nlen <= r_nlen;
            r_o_clen <= r_clen;
            r_o_hash <= hstat.hash;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tdata  = {r_o_hash, r_o_clen, r_o_nlen, r_o_mode, r_o_byte};

`ifndef NO_ASSERTIONS
    // the halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt cleared without reset");

    // no beat is taken while the permutation table is loading
    a_no_accept_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !hstat.ready |-> !s_axis_tready)
        else $error("input accepted during table load");

    // a halted result is only produced once the halt is set
    a_halt_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_kind == K_HALT) |-> r_halt)
        else $error("halted result without halt");

    // pending stage only fills after the table is loaded
    a_pend_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> hstat.ready)
        else $error("pending beat during table load");
`endif

endmodule

/* rtl/ardc_ram.sv */
module ardc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port; read data holds when idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ardc_hash.sv */
module ardc_hash (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ardc_pkg::t_hash_req   i_req,
    output ardc_pkg::t_hash_stat  o_stat
);

    import ardc_pkg::*;

    logic [7:0] r_fill_idx;
    logic       r_fill_busy;
    logic       r_h_valid;   // running hash lives in the RAM read register
    logic [7:0] ram_rdata;
    logic [7:0] h_cur;
    logic [7:0] rd_addr;

    // load the permutation into the table RAM, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_idx  <= '0;
            r_fill_busy <= 1'b1;
        end else if (r_fill_busy) begin
            r_fill_idx <= r_fill_idx + 8'd1;
            if (r_fill_idx == 8'hFF) begin
                r_fill_busy <= 1'b0;
            end
        end
    end

    // hash is zero until the first byte is hashed after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else if (i_req.en) begin
            r_h_valid <= 1'b1;
        end
    end

    assign h_cur   = r_h_valid ? ram_rdata : 8'd0;
    // h = T[h ^ byte]; a magic byte starts over from zero
    assign rd_addr = (i_req.restart ? 8'd0 : h_cur) ^ i_req.data;

    ardc_ram #(
        .WIDTH (8),
        .DEPTH (256)
    ) u_perm_ram (
        .i_clk   (i_clk),
        .i_we    (r_fill_busy),
        .i_waddr (r_fill_idx),
        .i_wdata (PERM[r_fill_idx]),
        .i_re    (i_req.en),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign o_stat.ready = !r_fill_busy;
    assign o_stat.hash  = h_cur;

endmodule
